[rtl/core/sdfpa_pkg.sv]
// shared types and constants for the signed decimal fixed-point adder
package sdfpa_pkg;

    // width of every packed bcd field and the number of nibbles it holds
    localparam int FIELD_WIDTH  = 32;
    localparam int FIELD_DIGITS = FIELD_WIDTH / 4;

    typedef logic [FIELD_WIDTH-1:0] field_t;
    typedef logic [3:0]             digit_t;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_ADDEND_NEGATIVE   = 2'd0;
    localparam cfg_index_t CFG_ADDEND_INT_DIGITS = 2'd1;
    localparam cfg_index_t CFG_ADDEND_FRAC_DIGITS = 2'd2;

    // addend after reset: -123.456
    localparam logic   ADDEND_NEGATIVE_RST    = 1'b1;
    localparam field_t ADDEND_INT_DIGITS_RST  = 32'h0000_0123;
    localparam field_t ADDEND_FRAC_DIGITS_RST = 32'h4560_0000;

    // one signed decimal number: sign and packed bcd digits
    typedef struct packed {
        logic   negative;
        field_t int_digits;
        field_t frac_digits;
    } number_t;

    // one sum with its status flags
    typedef struct packed {
        logic   negative;
        field_t int_digits;
        field_t frac_digits;
        logic   overflow;
        logic   digit_error;
    } result_t;

endpackage

[rtl/core/sdfpa_cfg_regs.sv]
// addend configuration registers with index decode
module sdfpa_cfg_regs
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  sdfpa_pkg::cfg_index_t cfg_index,
    input  sdfpa_pkg::field_t     cfg_data,
    output sdfpa_pkg::number_t    addend
);
    import sdfpa_pkg::*;

    number_t addend_reg;
    number_t addend_next;

    // decode the write; an unknown index leaves the addend alone
    always_comb
    begin
        addend_next = addend_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ADDEND_NEGATIVE:    addend_next.negative    = cfg_data[0];
                CFG_ADDEND_INT_DIGITS:  addend_next.int_digits  = cfg_data;
                CFG_ADDEND_FRAC_DIGITS: addend_next.frac_digits = cfg_data;
                default:                addend_next = addend_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addend_reg.negative    <= ADDEND_NEGATIVE_RST;
            addend_reg.int_digits  <= ADDEND_INT_DIGITS_RST;
            addend_reg.frac_digits <= ADDEND_FRAC_DIGITS_RST;
        end
        else
        begin
            addend_reg <= addend_next;
        end
    end

    assign addend = addend_reg;

endmodule

[rtl/core/sdfpa_arith.sv]
// single-pass signed-magnitude bcd add and subtract with lookahead carries
module sdfpa_arith #(
    parameter int INT_DIGITS  = 8,
    parameter int FRAC_DIGITS = 8
)
(
    input  sdfpa_pkg::number_t operand,
    input  sdfpa_pkg::number_t addend,
    output sdfpa_pkg::result_t result
);
    import sdfpa_pkg::*;

    localparam int N         = INT_DIGITS + FRAC_DIGITS;
    localparam int INT_USED  = (INT_DIGITS < FIELD_DIGITS) ? INT_DIGITS : FIELD_DIGITS;
    localparam int FRAC_USED = (FRAC_DIGITS < FIELD_DIGITS) ? FRAC_DIGITS : FIELD_DIGITS;

    // carry into every digit and out of the top, from digit generate and propagate
    // bits, worked out by one binary add of (g | p) and g
    function automatic logic [N:0] lookahead(input logic [N-1:0] g, input logic [N-1:0] p);
        logic [N-1:0] x;
        logic [N:0]   s;
        logic [N:0]   c;
        x = g | p;
        s = {1'b0, x} + {1'b0, g};
        c = {s[N], s[N-1:0] ^ x ^ g};
        return c;
    endfunction

    digit_t [N-1:0] a_dig;
    digit_t [N-1:0] b_dig;
    digit_t [N-1:0] sum_dig;
    digit_t [N-1:0] dab_dig;
    digit_t [N-1:0] dba_dig;
    digit_t [N-1:0] res_dig;
    logic   [4:0]   pair_sum [N];
    logic   [N-1:0] add_g;
    logic   [N-1:0] add_p;
    logic   [N-1:0] ab_g;
    logic   [N-1:0] ba_g;
    logic   [N-1:0] eq_p;
    logic   [N:0]   add_c;
    logic   [N:0]   ab_c;
    logic   [N:0]   ba_c;
    logic           same_sign;
    logic           bad_digit;
    logic           is_zero;
    logic           sign_raw;

    // unpack both numbers into digits, least significant first
    always_comb
    begin
        a_dig = '0;
        b_dig = '0;
        for (int i = 0; i < FRAC_USED; i++)
        begin
            a_dig[i] = operand.frac_digits[4*i +: 4];
            b_dig[i] = addend.frac_digits[4*i +: 4];
        end
        for (int i = 0; i < INT_USED; i++)
        begin
            a_dig[FRAC_DIGITS + i] = operand.int_digits[4*i +: 4];
            b_dig[FRAC_DIGITS + i] = addend.int_digits[4*i +: 4];
        end
    end

    // nibble above nine in either number
    always_comb
    begin
        bad_digit = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            if (a_dig[i] > 4'd9 || b_dig[i] > 4'd9)
            begin
                bad_digit = 1'b1;
            end
        end
    end

    // per-digit generate and propagate for the adder and both subtractors
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            pair_sum[i] = {1'b0, a_dig[i]} + {1'b0, b_dig[i]};
            add_g[i]    = (pair_sum[i] >= 5'd10);
            add_p[i]    = (pair_sum[i] == 5'd9);
            ab_g[i]     = (a_dig[i] < b_dig[i]);
            ba_g[i]     = (b_dig[i] < a_dig[i]);
            eq_p[i]     = (a_dig[i] == b_dig[i]);
        end
    end

    assign add_c = lookahead(add_g, add_p);
    assign ab_c  = lookahead(ab_g, eq_p);
    assign ba_c  = lookahead(ba_g, eq_p);

    // result digits with decimal correction, raw nibbles kept to four bits
    always_comb
    begin
        logic [4:0] t;
        for (int i = 0; i < N; i++)
        begin
            t = pair_sum[i] + {4'd0, add_c[i]};
            if (t >= 5'd10)
            begin
                t = t - 5'd10;
            end
            sum_dig[i] = t[3:0];

            t = {1'b0, a_dig[i]} - {1'b0, b_dig[i]} - {4'd0, ab_c[i]};
            if (t[4])
            begin
                t = t + 5'd10;
            end
            dab_dig[i] = t[3:0];

            t = {1'b0, b_dig[i]} - {1'b0, a_dig[i]} - {4'd0, ba_c[i]};
            if (t[4])
            begin
                t = t + 5'd10;
            end
            dba_dig[i] = t[3:0];
        end
    end

    // pick the path; a borrow out of a - b means the addend is larger
    assign same_sign = (operand.negative == addend.negative);

    always_comb
    begin
        if (same_sign)
        begin
            res_dig  = sum_dig;
            sign_raw = operand.negative;
        end
        else if (!ab_c[N])
        begin
            res_dig  = dab_dig;
            sign_raw = operand.negative;
        end
        else
        begin
            res_dig  = dba_dig;
            sign_raw = addend.negative;
        end
    end

    assign is_zero = (res_dig == '0);

    // pack the sum back into bcd fields
    always_comb
    begin
        result             = '0;
        result.negative    = sign_raw & ~is_zero;
        result.overflow    = same_sign & add_c[N];
        result.digit_error = bad_digit;
        for (int i = 0; i < FRAC_USED; i++)
        begin
            result.frac_digits[4*i +: 4] = res_dig[i];
        end
        for (int i = 0; i < INT_USED; i++)
        begin
            result.int_digits[4*i +: 4] = res_dig[FRAC_DIGITS + i];
        end
    end

endmodule

[rtl/core/signed_decimal_fixed_point_adder_core.sv]
// Signed decimal fixed-point adder: adds each incoming signed packed-bcd number to a
// configured signed addend (-123.456 after reset) and returns one sum per transaction.
// Throughput is one transaction per clock while out_ready stays high. An operand is held
// in the operand register and its sum in the result register; the whole decimal add or
// subtract is done combinationally between them, using lookahead carries over all digits.
// Equal signs add magnitudes and flag overflow (the sum wraps); unequal signs subtract the
// smaller magnitude. A zero sum is positive. Any nibble above nine sets digit_error.
// The addend registers are written through the cfg channel, which is always ready; write
// them only while no transaction is in flight.
module signed_decimal_fixed_point_adder_core #(
    parameter int INT_DIGITS  = 8,
    parameter int FRAC_DIGITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  sdfpa_pkg::cfg_index_t cfg_index,
    input  sdfpa_pkg::field_t     cfg_data,
    // operand channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operand_negative,
    input  sdfpa_pkg::field_t     operand_int_digits,
    input  sdfpa_pkg::field_t     operand_frac_digits,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  sum_negative,
    output sdfpa_pkg::field_t     sum_int_digits,
    output sdfpa_pkg::field_t     sum_frac_digits,
    output logic                  overflow,
    output logic                  digit_error
);
    import sdfpa_pkg::*;

    number_t addend;
    number_t operand_reg;
    number_t operand_next;
    result_t arith_result;
    result_t result_reg;
    result_t result_next;
    logic    op_valid_reg;
    logic    op_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    in_xfer;
    logic    res_load;
    logic    op_advance;

    assign cfg_ready = 1'b1;

    sdfpa_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .addend    (addend)
    );

    sdfpa_arith #(
        .INT_DIGITS  (INT_DIGITS),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_arith
    (
        .operand (operand_reg),
        .addend  (addend),
        .result  (arith_result)
    );

    // handshake: result register frees when empty or taken this cycle
    assign res_load   = !out_valid_reg || out_ready;
    assign op_advance = op_valid_reg && res_load;
    assign in_ready   = !op_valid_reg || res_load;
    assign in_xfer    = in_valid && in_ready;

    always_comb
    begin
        op_valid_next = op_valid_reg;
        if (in_xfer)
        begin
            op_valid_next = 1'b1;
        end
        else if (op_advance)
        begin
            op_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (op_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // payload next values
    always_comb
    begin
        operand_next = operand_reg;
        if (in_xfer)
        begin
            operand_next.negative    = operand_negative;
            operand_next.int_digits  = operand_int_digits;
            operand_next.frac_digits = operand_frac_digits;
        end
        result_next = op_advance ? arith_result : result_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        operand_reg <= operand_next;
        result_reg  <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign sum_negative    = result_reg.negative;
    assign sum_int_digits  = result_reg.int_digits;
    assign sum_frac_digits = result_reg.frac_digits;
    assign overflow        = result_reg.overflow;
    assign digit_error     = result_reg.digit_error;

endmodule

[tb/tb_signed_decimal_fixed_point_adder_core.sv]
// testbench for the signed decimal fixed-point adder core with its own sum predictor
`timescale 1ns / 100ps

module tb_signed_decimal_fixed_point_adder_core;

    import sdfpa_pkg::*;

    localparam int INT_DIGITS     = 8;
    localparam int FRAC_DIGITS    = 8;
    localparam int TOTAL_DIGITS   = INT_DIGITS + FRAC_DIGITS;
    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 8;
    localparam int IDLE_PERCENT   = 11;
    localparam int STALL_CYCLES   = 300;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 50;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    // index past the register list, writes to it must change nothing
    localparam cfg_index_t CFG_SPARE_INDEX = 2'd3;

    // one row of the directed table, sum is only meaningful when typed is set
    typedef struct packed {
        logic    typed;
        number_t item;
        result_t sum;
    } directed_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    field_t     cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic       operand_negative;
    field_t     operand_int_digits;
    field_t     operand_frac_digits;
    logic       out_valid;
    logic       out_ready;
    logic       sum_negative;
    field_t     sum_int_digits;
    field_t     sum_frac_digits;
    logic       overflow;
    logic       digit_error;

    // addend as the predictor sees it
    logic   addend_sign;
    field_t addend_int;
    field_t addend_frac;

    result_t       expected_sums [$];
    directed_row_t directed_rows [$];

    bit quiet_stretch;
    bit stall_request;
    int mismatch_count;
    int sent_count;
    int checked_count;
    int setting_count;

    signed_decimal_fixed_point_adder_core #(
        .INT_DIGITS  (INT_DIGITS),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .operand_negative    (operand_negative),
        .operand_int_digits  (operand_int_digits),
        .operand_frac_digits (operand_frac_digits),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .sum_negative        (sum_negative),
        .sum_int_digits      (sum_int_digits),
        .sum_frac_digits     (sum_frac_digits),
        .overflow            (overflow),
        .digit_error         (digit_error)
    );

    always #(CLK_HALF) clk = ~clk;

    // signed decimal sum of one operand and the current addend
    function automatic result_t predict_sum(input number_t op);
        int      a [TOTAL_DIGITS];
        int      b [TOTAL_DIGITS];
        int      r [TOTAL_DIGITS];
        int      carry;
        int      d;
        logic    op_ge;
        logic    decided;
        logic    is_zero;
        result_t res;
        res = '0;
        for (int i = 0; i < FRAC_DIGITS; i++)
        begin
            a[i] = op.frac_digits[4*i +: 4];
            b[i] = addend_frac[4*i +: 4];
        end
        for (int i = 0; i < INT_DIGITS; i++)
        begin
            a[FRAC_DIGITS+i] = op.int_digits[4*i +: 4];
            b[FRAC_DIGITS+i] = addend_int[4*i +: 4];
        end
        for (int i = 0; i < TOTAL_DIGITS; i++)
        begin
            if (a[i] > 9 || b[i] > 9)
                res.digit_error = 1'b1;
        end
        carry = 0;
        if (op.negative == addend_sign)
        begin
            // add magnitudes, decimal carry runs up through the point
            for (int i = 0; i < TOTAL_DIGITS; i++)
            begin
                d = a[i] + b[i] + carry;
                if (d >= 10)
                begin
                    d     = d - 10;
                    carry = 1;
                end
                else
                    carry = 0;
                r[i] = d & 15;
            end
            res.overflow = (carry != 0);
            res.negative = op.negative;
        end
        else
        begin
            // larger raw magnitude decided from the top digit down
            op_ge   = 1'b1;
            decided = 1'b0;
            for (int i = TOTAL_DIGITS - 1; i >= 0; i--)
            begin
                if (!decided && a[i] != b[i])
                begin
                    op_ge   = (a[i] > b[i]);
                    decided = 1'b1;
                end
            end
            for (int i = 0; i < TOTAL_DIGITS; i++)
            begin
                d = op_ge ? a[i] - b[i] - carry : b[i] - a[i] - carry;
                if (d < 0)
                begin
                    d     = d + 10;
                    carry = 1;
                end
                else
                    carry = 0;
                r[i] = d & 15;
            end
            res.negative = op_ge ? op.negative : addend_sign;
        end
        // zero is always positive, wrapped or not
        is_zero = 1'b1;
        for (int i = 0; i < TOTAL_DIGITS; i++)
        begin
            if (r[i] != 0)
                is_zero = 1'b0;
        end
        if (is_zero)
            res.negative = 1'b0;
        for (int i = 0; i < FRAC_DIGITS; i++)
            res.frac_digits[4*i +: 4] = 4'(r[i]);
        for (int i = 0; i < INT_DIGITS; i++)
            res.int_digits[4*i +: 4] = 4'(r[FRAC_DIGITS+i]);
        return res;
    endfunction

    // packed bcd value with the given number of random low digits
    function automatic field_t random_bcd(input int digits);
        field_t value;
        value = '0;
        for (int i = 0; i < digits; i++)
            value[4*i +: 4] = 4'($urandom_range(0, 9));
        return value;
    endfunction

    function automatic directed_row_t typed_row(input logic neg, input field_t ip,
                                                input field_t fp, input logic sneg,
                                                input field_t sint, input field_t sfrac,
                                                input logic ovf, input logic err);
        directed_row_t row;
        row.typed            = 1'b1;
        row.item.negative    = neg;
        row.item.int_digits  = ip;
        row.item.frac_digits = fp;
        row.sum.negative     = sneg;
        row.sum.int_digits   = sint;
        row.sum.frac_digits  = sfrac;
        row.sum.overflow     = ovf;
        row.sum.digit_error  = err;
        return row;
    endfunction

    function automatic directed_row_t open_row(input logic neg, input field_t ip,
                                               input field_t fp);
        directed_row_t row;
        row                  = '0;
        row.item.negative    = neg;
        row.item.int_digits  = ip;
        row.item.frac_digits = fp;
        return row;
    endfunction

    // one config transaction, entered and left at a falling edge
    task automatic write_addend_reg(input cfg_index_t idx, input field_t data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ADDEND_NEGATIVE:    addend_sign = data[0];
            CFG_ADDEND_INT_DIGITS:  addend_int  = data;
            CFG_ADDEND_FRAC_DIGITS: addend_frac = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one operand transaction with optional leading gap, expectation queued on acceptance
    task automatic send_operand(input number_t item, input result_t sum);
        if (!quiet_stretch)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid            = 1'b1;
        operand_negative    = item.negative;
        operand_int_digits  = item.int_digits;
        operand_frac_digits = item.frac_digits;
        do
            @(posedge clk);
        while (!in_ready);
        expected_sums.push_back(sum);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic wait_drained;
        while (expected_sums.size() != 0)
            @(negedge clk);
    endtask

    // result side ready, with random idling and one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready     = 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
            end
            out_ready = quiet_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_sums
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sums.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                mismatch_count++;
            end
            else
            begin
                want = expected_sums.pop_front();
                checked_count++;
                check_field("sum_negative", 32'(want.negative), 32'(sum_negative));
                check_field("sum_int_digits", want.int_digits, sum_int_digits);
                check_field("sum_frac_digits", want.frac_digits, sum_frac_digits);
                check_field("overflow", 32'(want.overflow), 32'(overflow));
                check_field("digit_error", 32'(want.digit_error), 32'(digit_error));
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        number_t     item;
        int          pick;
        int          k;
        logic [63:0] mag;
        logic        next_sign;
        field_t      next_int;
        field_t      next_frac;

        rst_n               = 1'b0;
        cfg_valid           = 1'b0;
        cfg_index           = CFG_ADDEND_NEGATIVE;
        cfg_data            = '0;
        in_valid            = 1'b0;
        operand_negative    = 1'b0;
        operand_int_digits  = '0;
        operand_frac_digits = '0;
        addend_sign         = ADDEND_NEGATIVE_RST;
        addend_int          = ADDEND_INT_DIGITS_RST;
        addend_frac         = ADDEND_FRAC_DIGITS_RST;
        quiet_stretch       = 1'b0;
        stall_request       = 1'b0;
        mismatch_count      = 0;
        sent_count          = 0;
        checked_count       = 0;
        setting_count       = 1;

        // directed table against the reset addend -123.456
        directed_rows.push_back(typed_row(1'b0, 32'h0000_0123, 32'h4560_0000,
                                          1'b0, 32'h0, 32'h0, 1'b0, 1'b0));
        directed_rows.push_back(typed_row(1'b1, 32'h0000_0123, 32'h4560_0000,
                                          1'b1, 32'h0000_0246, 32'h9120_0000, 1'b0, 1'b0));
        directed_rows.push_back(typed_row(1'b0, 32'h0, 32'h0,
                                          1'b1, 32'h0000_0123, 32'h4560_0000, 1'b0, 1'b0));
        directed_rows.push_back(typed_row(1'b1, 32'h0, 32'h0,
                                          1'b1, 32'h0000_0123, 32'h4560_0000, 1'b0, 1'b0));
        directed_rows.push_back(typed_row(1'b0, 32'h0000_0200, 32'h0,
                                          1'b0, 32'h0000_0076, 32'h5440_0000, 1'b0, 1'b0));
        directed_rows.push_back(typed_row(1'b0, 32'h9999_9999, 32'h9999_9999,
                                          1'b0, 32'h9999_9876, 32'h5439_9999, 1'b0, 1'b0));
        directed_rows.push_back(typed_row(1'b1, 32'h9999_9999, 32'h9999_9999,
                                          1'b1, 32'h0000_0123, 32'h4559_9999, 1'b1, 1'b0));
        // sum wraps to exactly zero: positive with overflow
        directed_rows.push_back(typed_row(1'b1, 32'h9999_9876, 32'h5440_0000,
                                          1'b0, 32'h0, 32'h0, 1'b1, 1'b0));
        directed_rows.push_back(typed_row(1'b0, 32'h0000_0123, 32'h4560_0001,
                                          1'b0, 32'h0, 32'h0000_0001, 1'b0, 1'b0));
        directed_rows.push_back(typed_row(1'b0, 32'h0000_0123, 32'h4559_9999,
                                          1'b1, 32'h0, 32'h0000_0001, 1'b0, 1'b0));
        directed_rows.push_back(typed_row(1'b1, 32'h0000_000a, 32'h0,
                                          1'b1, 32'h0000_0133, 32'h4560_0000, 1'b0, 1'b1));
        directed_rows.push_back(open_row(1'b0, 32'hffff_ffff, 32'hffff_ffff));
        directed_rows.push_back(open_row(1'b1, 32'hffff_ffff, 32'hffff_ffff));
        directed_rows.push_back(open_row(1'b0, 32'h0000_000a, 32'h0));
        directed_rows.push_back(open_row(1'b1, 32'h0, 32'h0000_000f));
        directed_rows.push_back(open_row(1'b0, 32'ha000_0000, 32'hf000_0000));
        directed_rows.push_back(open_row(1'b0, 32'h0000_0123, 32'h4560_000a));
        directed_rows.push_back(open_row(1'b1, 32'h5555_5555, 32'haaaa_aaaa));
        directed_rows.push_back(open_row(1'b0, 32'haaaa_aaaa, 32'h5555_5555));
        directed_rows.push_back(open_row(1'b0, 32'h0, 32'h0000_0001));
        directed_rows.push_back(open_row(1'b1, 32'h9999_9999, 32'h0));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
            send_operand(directed_rows[r].item,
                         directed_rows[r].typed ? directed_rows[r].sum
                                                : predict_sum(directed_rows[r].item));
        in_valid = 1'b0;

        // random phases, one addend setting each
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    next_sign = 1'b0;
                    next_int  = '0;
                    next_frac = '0;
                end
                1:
                begin
                    next_sign = 1'b1;
                    next_int  = 32'h9999_9999;
                    next_frac = 32'h9999_9999;
                end
                2:
                begin
                    next_sign = 1'b0;
                    next_int  = 32'h9999_9999;
                    next_frac = 32'h9999_9999;
                end
                3:
                begin
                    next_sign = 1'b1;
                    next_int  = '0;
                    next_frac = '0;
                end
                6:
                begin
                    // raw nibbles, every sum flags a digit error
                    next_sign = 1'($urandom_range(0, 1));
                    next_int  = $urandom();
                    next_frac = $urandom() | 32'h0000_000f;
                end
                default:
                begin
                    next_sign = phase[0];
                    next_int  = random_bcd($urandom_range(1, 8));
                    next_frac = random_bcd(8);
                end
            endcase
            write_addend_reg(CFG_ADDEND_NEGATIVE, {31'($urandom()), next_sign});
            write_addend_reg(CFG_ADDEND_INT_DIGITS, next_int);
            write_addend_reg(CFG_ADDEND_FRAC_DIGITS, next_frac);
            write_addend_reg(CFG_SPARE_INDEX, $urandom());
            setting_count++;

            quiet_stretch = (phase == 3);
            if (phase == 1)
                stall_request = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick          = $urandom_range(0, 99);
                item.negative = 1'($urandom_range(0, 1));
                if (pick < 40)
                begin
                    item.int_digits  = random_bcd(8);
                    item.frac_digits = random_bcd(8);
                end
                else if (pick < 55)
                begin
                    item.int_digits  = random_bcd($urandom_range(0, 3));
                    item.frac_digits = random_bcd(8) << (4 * $urandom_range(0, 7));
                end
                else if (pick < 75)
                begin
                    // close to the addend magnitude, often exactly on it
                    mag = {addend_int, addend_frac};
                    if ($urandom_range(0, 99) >= 30)
                    begin
                        k = $urandom_range(0, TOTAL_DIGITS - 1);
                        mag[4*k +: 4] = 4'($urandom_range(0, 9));
                    end
                    item.int_digits  = mag[63:32];
                    item.frac_digits = mag[31:0];
                end
                else if (pick < 85)
                begin
                    item.int_digits  = $urandom_range(0, 1) ? 32'h9999_9999 : 32'h0;
                    item.frac_digits = $urandom_range(0, 1) ? 32'h9999_9999 : 32'h0;
                end
                else
                begin
                    item.int_digits  = $urandom();
                    item.frac_digits = $urandom();
                end
                send_operand(item, predict_sum(item));
            end
            in_valid      = 1'b0;
            quiet_stretch = 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_sums.size() != 0)
        begin
            $error("%0d expected sums never arrived", expected_sums.size());
            mismatch_count++;
        end

        $display("covered %0d operands (%0d from the directed table) over %0d addend settings",
                 sent_count, directed_rows.size(), setting_count);
        $display("checked %0d sums, with one %0d-cycle result stall, %0d mismatches",
                 checked_count, STALL_CYCLES, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/sdfpa_pkg.sv
rtl/core/sdfpa_cfg_regs.sv
rtl/core/sdfpa_arith.sv
rtl/core/signed_decimal_fixed_point_adder_core.sv
tb/tb_signed_decimal_fixed_point_adder_core.sv
